@@ src/multi_pattern_string_matcher_assert.svh @@
// ============================================================================
// multi_pattern_string_matcher_assert
// assertion macros for the string matcher, empty bodies under synthesis
// ============================================================================
`ifndef MULTI_PATTERN_STRING_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_STRING_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every clock edge out of reset
`define MPSM_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MPSM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`else

`define MPSM_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons)
`define MPSM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

@@ src/mpsm_pkg.sv @@
// ============================================================================
// mpsm_pkg
// shared types, constants and helpers of the multi-pattern string matcher
// ============================================================================
package mpsm_pkg;

    localparam int MAX_NODES = 1024;
    localparam int ALPHA     = 26;
    localparam int MAX_PAT   = 64;
    localparam int NODE_W    = 10;
    localparam int CNT_W     = 11;
    localparam int LETTER_W  = 5;
    localparam int PID_W     = 6;

    // function codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_BUILD  = 2'd1;
    localparam logic [1:0] FUNC_SCAN   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EARLY = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [LETTER_W-1:0] letter;
        logic                first_letter;
        logic                last_letter;
        logic [PID_W-1:0]    pattern_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [MAX_PAT-1:0] match_mask;
        logic               match_any;
        logic [NODE_W-1:0]  node_index;
    } rsp_t;

    typedef logic [ALPHA-1:0][NODE_W-1:0] kids_t;

    // one trie node: goto row, fail link, merged pattern mask
    typedef struct packed {
        kids_t              kids;
        logic [NODE_W-1:0]  fail;
        logic [MAX_PAT-1:0] mask;
    } node_rec_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        node_rec_t         wr_data;
    } node_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
    } queue_req_t;

    typedef enum logic [4:0] {
        S_BOOT,
        S_CLEAR,
        S_IDLE,
        S_INS_RD,
        S_INS_NEW,
        S_INS_TAG,
        S_SCAN_RD,
        S_SCAN_MASK,
        S_B_ROOT,
        S_B_RC,
        S_B_DEQ,
        S_B_QW,
        S_B_NROW,
        S_B_CH,
        S_B_WALK,
        S_B_CREC,
        S_B_CWR
    } state_t;

    function automatic rsp_t make_rsp(logic [1:0] st, logic [MAX_PAT-1:0] m,
                                      logic [NODE_W-1:0] n);
        rsp_t r;
        r.status     = st;
        r.match_mask = m;
        r.match_any  = |m;
        r.node_index = n;
        return r;
    endfunction

endpackage

@@ src/mpsm_node_ram.sv @@
// ============================================================================
// mpsm_node_ram
// node record memory, one read and one write port, registered read data
// ============================================================================
module mpsm_node_ram
    import mpsm_pkg::*;
(
    input  logic      clk,
    input  node_req_t req,
    output node_rec_t rd_data
);

    node_rec_t mem [MAX_NODES];
    node_rec_t rd_data_reg;

    // write, and read with forwarding of a same-address write
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            if (req.wr_en && (req.wr_addr == req.rd_addr))
            begin
                rd_data_reg <= req.wr_data;
            end
            else
            begin
                rd_data_reg <= mem[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mpsm_queue_ram.sv @@
// ============================================================================
// mpsm_queue_ram
// breadth-first queue storage, one read and one write port
// ============================================================================
module mpsm_queue_ram
    import mpsm_pkg::*;
(
    input  logic              clk,
    input  queue_req_t        req,
    output logic [NODE_W-1:0] rd_data
);

    logic [NODE_W-1:0] mem [MAX_NODES];
    logic [NODE_W-1:0] rd_data_reg;

    // queue slots are always written before they are read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/mpsm_ctrl.sv @@
// ============================================================================
// mpsm_ctrl
// sequencer for insert, build, scan and clear over the node memory
// ============================================================================
module mpsm_ctrl
    import mpsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output rsp_t              rsp,
    output node_req_t         node_req,
    input  node_rec_t         node_rd,
    output queue_req_t        q_req,
    input  logic [NODE_W-1:0] q_rd
);

    state_t state_reg, state_next;

    cmd_t               cmd_reg, cmd_next;
    logic [NODE_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               built_reg, built_next;
    logic [NODE_W-1:0]  walk_reg, walk_next;
    logic [NODE_W-1:0]  ch_reg, ch_next;
    logic [NODE_W-1:0]  nfail_reg, nfail_next;
    logic [NODE_W-1:0]  newfail_reg, newfail_next;
    logic [MAX_PAT-1:0] fmask_reg, fmask_next;
    kids_t              kids_reg, kids_next;
    logic [LETTER_W-1:0] c_reg, c_next;
    logic [NODE_W-1:0]  head_reg, head_next;
    logic [NODE_W-1:0]  tail_reg, tail_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic                letter_ok;
    logic [NODE_W-1:0]   start_cur;
    logic [NODE_W-1:0]   goto_ins;
    logic [NODE_W-1:0]   goto_cmd;
    logic [NODE_W-1:0]   goto_c;
    logic                tag_en;
    logic [MAX_PAT-1:0]  tag_bit;
    logic                table_full;
    logic                last_c;
    node_rec_t           rec_mod;

    // decoded helpers
    assign letter_ok  = cmd.letter < LETTER_W'(ALPHA);
    assign start_cur  = cmd.first_letter ? '0 : cursor_reg;
    assign goto_ins   = node_rd.kids[cmd_reg.letter];
    assign goto_cmd   = node_rd.kids[cmd_reg.letter];
    assign goto_c     = node_rd.kids[c_reg];
    assign tag_en     = cmd_reg.last_letter &&
                        ({1'b0, cmd_reg.pattern_id} < (PID_W+1)'(MAX_PAT));
    assign tag_bit    = MAX_PAT'(1) << cmd_reg.pattern_id;
    assign table_full = count_reg >= CNT_W'(MAX_NODES);
    assign last_c     = c_reg == LETTER_W'(ALPHA - 1);

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_BOOT;
            cursor_reg <= '0;
            count_reg  <= CNT_W'(1);
            built_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            c_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            built_reg  <= built_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            c_reg      <= c_next;
            done_reg   <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        walk_reg    <= walk_next;
        ch_reg      <= ch_next;
        nfail_reg   <= nfail_next;
        newfail_reg <= newfail_next;
        fmask_reg   <= fmask_next;
        kids_reg    <= kids_next;
        rsp_reg     <= rsp_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_BOOT:    state_next = S_IDLE;
            S_CLEAR:   state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        FUNC_INSERT: state_next = letter_ok ? S_INS_RD : S_IDLE;
                        FUNC_BUILD:  state_next = S_B_ROOT;
                        FUNC_SCAN:   state_next = (built_reg && letter_ok) ? S_SCAN_RD
                                                                           : S_IDLE;
                        default:     state_next = S_CLEAR;
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (goto_ins != '0)
                begin
                    state_next = tag_en ? S_INS_TAG : S_IDLE;
                end
                else
                begin
                    state_next = table_full ? S_IDLE : S_INS_NEW;
                end
            end
            S_INS_NEW:   state_next = S_IDLE;
            S_INS_TAG:   state_next = S_IDLE;
            S_SCAN_RD:
            begin
                if (goto_cmd != '0)
                begin
                    state_next = S_SCAN_MASK;
                end
                else if (walk_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN_MASK: state_next = S_IDLE;
            S_B_ROOT:    state_next = S_B_RC;
            S_B_RC:      state_next = last_c ? S_B_DEQ : S_B_RC;
            S_B_DEQ:     state_next = (head_reg != tail_reg) ? S_B_QW : S_IDLE;
            S_B_QW:      state_next = S_B_NROW;
            S_B_NROW:    state_next = S_B_CH;
            S_B_CH:
            begin
                if (kids_reg[c_reg] != '0)
                begin
                    state_next = S_B_WALK;
                end
                else if (last_c)
                begin
                    state_next = S_B_DEQ;
                end
            end
            S_B_WALK:
            begin
                if (goto_c != '0 || walk_reg == '0)
                begin
                    state_next = S_B_CREC;
                end
            end
            S_B_CREC:    state_next = S_B_CWR;
            S_B_CWR:     state_next = last_c ? S_B_DEQ : S_B_CH;
            default:     state_next = S_BOOT;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        cmd_next     = cmd_reg;
        cursor_next  = cursor_reg;
        count_next   = count_reg;
        built_next   = built_reg;
        walk_next    = walk_reg;
        ch_next      = ch_reg;
        nfail_next   = nfail_reg;
        newfail_next = newfail_reg;
        fmask_next   = fmask_reg;
        kids_next    = kids_reg;
        c_next       = c_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        node_req     = '0;
        q_req        = '0;
        rec_mod      = node_rd;
        case (state_reg)
            // root record init after reset
            S_BOOT:
            begin
                node_req.wr_en   = 1'b1;
                node_req.wr_addr = '0;
                node_req.wr_data = '0;
                count_next       = CNT_W'(1);
                cursor_next      = '0;
                built_next       = 1'b0;
            end
            // clear behaves as reset and answers
            S_CLEAR:
            begin
                node_req.wr_en   = 1'b1;
                node_req.wr_addr = '0;
                node_req.wr_data = '0;
                count_next       = CNT_W'(1);
                cursor_next      = '0;
                built_next       = 1'b0;
                done_next        = 1'b1;
                rsp_next         = make_rsp(STATUS_OK, '0, '0);
            end
            // accept a transaction
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.func)
                        FUNC_INSERT:
                        begin
                            cursor_next = start_cur;
                            if (letter_ok)
                            begin
                                built_next       = 1'b0;
                                walk_next        = start_cur;
                                node_req.rd_en   = 1'b1;
                                node_req.rd_addr = start_cur;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(STATUS_OK, '0, start_cur);
                            end
                        end
                        FUNC_BUILD:
                        begin
                            node_req.rd_en   = 1'b1;
                            node_req.rd_addr = '0;
                            head_next        = '0;
                            tail_next        = '0;
                            c_next           = '0;
                        end
                        FUNC_SCAN:
                        begin
                            if (!built_reg)
                            begin
                                done_next = 1'b1;
                                rsp_next  = make_rsp(STATUS_EARLY, '0, cursor_reg);
                            end
                            else if (!letter_ok)
                            begin
                                cursor_next = '0;
                                done_next   = 1'b1;
                                rsp_next    = make_rsp(STATUS_OK, '0, '0);
                            end
                            else
                            begin
                                walk_next        = start_cur;
                                node_req.rd_en   = 1'b1;
                                node_req.rd_addr = start_cur;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // insert: follow an existing edge or make a new node
            S_INS_RD:
            begin
                if (goto_ins != '0)
                begin
                    cursor_next = goto_ins;
                    if (tag_en)
                    begin
                        walk_next        = goto_ins;
                        node_req.rd_en   = 1'b1;
                        node_req.rd_addr = goto_ins;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        rsp_next  = make_rsp(STATUS_OK, '0, goto_ins);
                    end
                end
                else if (table_full)
                begin
                    done_next = 1'b1;
                    rsp_next  = make_rsp(STATUS_FULL, '0, cursor_reg);
                end
                else
                begin
                    rec_mod.kids[cmd_reg.letter] = count_reg[NODE_W-1:0];
                    node_req.wr_en   = 1'b1;
                    node_req.wr_addr = walk_reg;
                    node_req.wr_data = rec_mod;
                    count_next       = count_reg + CNT_W'(1);
                    cursor_next      = count_reg[NODE_W-1:0];
                    walk_next        = count_reg[NODE_W-1:0];
                end
            end
            // fresh node record
            S_INS_NEW:
            begin
                node_req.wr_en        = 1'b1;
                node_req.wr_addr      = walk_reg;
                node_req.wr_data      = '0;
                node_req.wr_data.mask = tag_en ? tag_bit : '0;
                done_next             = 1'b1;
                rsp_next              = make_rsp(STATUS_OK, '0, walk_reg);
            end
            // tag an existing node
            S_INS_TAG:
            begin
                rec_mod.mask     = node_rd.mask | tag_bit;
                node_req.wr_en   = 1'b1;
                node_req.wr_addr = walk_reg;
                node_req.wr_data = rec_mod;
                done_next        = 1'b1;
                rsp_next         = make_rsp(STATUS_OK, '0, walk_reg);
            end
            // scan: walk fail links until an edge exists or root
            S_SCAN_RD:
            begin
                if (goto_cmd != '0)
                begin
                    walk_next        = goto_cmd;
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = goto_cmd;
                end
                else if (walk_reg == '0)
                begin
                    cursor_next = '0;
                    done_next   = 1'b1;
                    rsp_next    = make_rsp(STATUS_OK, node_rd.mask, '0);
                end
                else
                begin
                    walk_next        = node_rd.fail;
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = node_rd.fail;
                end
            end
            S_SCAN_MASK:
            begin
                cursor_next = walk_reg;
                done_next   = 1'b1;
                rsp_next    = make_rsp(STATUS_OK, node_rd.mask, walk_reg);
            end
            // build: enqueue root children
            S_B_ROOT:
            begin
                kids_next = node_rd.kids;
                c_next    = '0;
            end
            S_B_RC:
            begin
                if (kids_reg[c_reg] != '0)
                begin
                    q_req.wr_en   = 1'b1;
                    q_req.wr_addr = tail_reg;
                    q_req.wr_data = kids_reg[c_reg];
                    tail_next     = tail_reg + NODE_W'(1);
                end
                c_next = last_c ? '0 : c_reg + LETTER_W'(1);
            end
            // dequeue next node or finish
            S_B_DEQ:
            begin
                if (head_reg != tail_reg)
                begin
                    q_req.rd_en   = 1'b1;
                    q_req.rd_addr = head_reg;
                    head_next     = head_reg + NODE_W'(1);
                end
                else
                begin
                    built_next  = 1'b1;
                    cursor_next = '0;
                    done_next   = 1'b1;
                    rsp_next    = make_rsp(STATUS_OK, '0, '0);
                end
            end
            S_B_QW:
            begin
                node_req.rd_en   = 1'b1;
                node_req.rd_addr = q_rd;
            end
            S_B_NROW:
            begin
                kids_next  = node_rd.kids;
                nfail_next = node_rd.fail;
                c_next     = '0;
            end
            // each child: enqueue and start the fail walk
            S_B_CH:
            begin
                if (kids_reg[c_reg] != '0)
                begin
                    q_req.wr_en      = 1'b1;
                    q_req.wr_addr    = tail_reg;
                    q_req.wr_data    = kids_reg[c_reg];
                    tail_next        = tail_reg + NODE_W'(1);
                    ch_next          = kids_reg[c_reg];
                    walk_next        = nfail_reg;
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = nfail_reg;
                end
                else
                begin
                    c_next = last_c ? '0 : c_reg + LETTER_W'(1);
                end
            end
            S_B_WALK:
            begin
                if (goto_c != '0)
                begin
                    newfail_next     = goto_c;
                    walk_next        = goto_c;
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = goto_c;
                end
                else if (walk_reg == '0)
                begin
                    newfail_next     = '0;
                    walk_next        = '0;
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = '0;
                end
                else
                begin
                    walk_next        = node_rd.fail;
                    node_req.rd_en   = 1'b1;
                    node_req.rd_addr = node_rd.fail;
                end
            end
            // fail target's mask is on the read port; fetch the child next
            S_B_CREC:
            begin
                fmask_next       = node_rd.mask;
                node_req.rd_en   = 1'b1;
                node_req.rd_addr = ch_reg;
            end
            // child record on the read port: store fail link and merged mask
            S_B_CWR:
            begin
                rec_mod.fail     = newfail_reg;
                rec_mod.mask     = node_rd.mask | fmask_reg;
                node_req.wr_en   = 1'b1;
                node_req.wr_addr = ch_reg;
                node_req.wr_data = rec_mod;
                c_next           = last_c ? '0 : c_reg + LETTER_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ src/multi_pattern_string_matcher.sv @@
// ============================================================================
// multi_pattern_string_matcher
// aho-corasick automaton: pattern insert, fail-link build, text scan
// ============================================================================
// A transaction is taken when start is high and busy is low; its single
// result appears on rsp for one cycle with done high and cannot be stalled.
// Insert answers without a node read for a letter outside the alphabet;
// else it reads the node, answers if the edge exists and no tag is set or
// the table is full, and otherwise writes the records first. Scan answers
// without a node read when refused or outside the alphabet; else it reads the
// current node, one more per fail link followed and the target node when an
// edge is taken. Clear writes the root record and answers. Build queues the
// root's children, then for each child of a queued node walks fail links and
// writes its fail link and merged mask. After reset the root is zeroed.
// ============================================================================
module multi_pattern_string_matcher
    import mpsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

`include "multi_pattern_string_matcher_assert.svh"

    node_req_t         node_req;
    node_rec_t         node_rd;
    queue_req_t        q_req;
    logic [NODE_W-1:0] q_rd;

    // sequencer
    mpsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .rsp      (rsp),
        .node_req (node_req),
        .node_rd  (node_rd),
        .q_req    (q_req),
        .q_rd     (q_rd)
    );

    // node table
    mpsm_node_ram u_node_ram (
        .clk     (clk),
        .req     (node_req),
        .rd_data (node_rd)
    );

    // breadth-first queue
    mpsm_queue_ram u_queue_ram (
        .clk     (clk),
        .req     (q_req),
        .rd_data (q_rd)
    );

    // checks
    `MPSM_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)
    `MPSM_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `MPSM_ASSERT_IMPLY(a_any_mask, clk, rst_n, done, rsp.match_any == (rsp.match_mask != '0))
    `MPSM_ASSERT_IMPLY(a_err_no_mask, clk, rst_n, done && rsp.status != STATUS_OK, rsp.match_mask == '0)

endmodule

@@ verif/tb_multi_pattern_string_matcher.sv @@
// ============================================================================
// tb_multi_pattern_string_matcher
// self-checking bench for the aho-corasick string matcher
// ============================================================================
// Runs a directed table first, then random pattern sets with build and scan.
// A final phase fills the node table to its limit. Each result is checked,
// oldest first, against the bench's trie model or a typed directed row.
// ============================================================================
module tb_multi_pattern_string_matcher;
    import mpsm_pkg::*;

    localparam int TIMEOUT_CYCLES = 4000000;
    localparam int RANDOM_ITEMS   = 90;

    typedef struct {
        cmd_t c;
        bit   typed;
        rsp_t r;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    rsp_t rsp;

    // trie model state
    logic [NODE_W-1:0]  trie_kid [0:MAX_NODES*ALPHA-1];
    logic [NODE_W-1:0]  trie_fail [0:MAX_NODES-1];
    logic [MAX_PAT-1:0] trie_mask [0:MAX_NODES-1];
    int unsigned        trie_nodes;
    int unsigned        trie_pos;
    bit                 trie_built;

    rsp_t     pending_rsp[$];
    dir_row_t dir_rows[$];
    int       errors;
    int       n_sent;
    int       quiet_cycles;
    bit       no_idle;

    multi_pattern_string_matcher i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_t mk(logic [1:0] f, logic [4:0] l, logic fl, logic ll,
                                logic [5:0] p);
        cmd_t c;
        c.func         = f;
        c.letter       = l;
        c.first_letter = fl;
        c.last_letter  = ll;
        c.pattern_id   = p;
        return c;
    endfunction

    // append one row to the directed table
    function automatic void add_row(cmd_t c, bit typed, rsp_t r);
        dir_row_t row;
        row.c     = c;
        row.typed = typed;
        row.r     = r;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic int unsigned kid(int unsigned n, int unsigned c);
        if (n >= MAX_NODES || c >= ALPHA)
            return 0;
        return trie_kid[n*ALPHA + c];
    endfunction

    function automatic void clear_trie();
        foreach (trie_kid[i]) trie_kid[i] = '0;
        foreach (trie_fail[i]) trie_fail[i] = '0;
        foreach (trie_mask[i]) trie_mask[i] = '0;
        trie_nodes = 1;
        trie_pos   = 0;
        trie_built = 1'b0;
    endfunction

    // breadth-first fail links with mask merge
    function automatic void build_links();
        int unsigned bq[MAX_NODES];
        int unsigned head, tail, n, ch, f;
        head = 0;
        tail = 0;
        trie_fail[0] = '0;
        for (int c = 0; c < ALPHA; c++)
        begin
            ch = kid(0, c);
            if (ch != 0 && tail < MAX_NODES)
            begin
                trie_fail[ch] = '0;
                bq[tail++] = ch;
            end
        end
        while (head < tail)
        begin
            n = bq[head++];
            for (int c = 0; c < ALPHA; c++)
            begin
                ch = kid(n, c);
                if (ch == 0)
                    continue;
                f = trie_fail[n];
                trie_fail[ch] = '0;
                for (int s = 0; s < MAX_NODES; s++)
                begin
                    if (kid(f, c) != 0)
                    begin
                        trie_fail[ch] = NODE_W'(kid(f, c));
                        break;
                    end
                    if (f == 0)
                        break;
                    f = trie_fail[f];
                end
                if (tail < MAX_NODES)
                    bq[tail++] = ch;
                trie_mask[ch] |= trie_mask[trie_fail[ch]];
            end
        end
        trie_built = 1'b1;
        trie_pos   = 0;
    endfunction

    // expected response of one transaction, updating the model
    function automatic rsp_t trie_step(cmd_t c);
        rsp_t        r;
        int unsigned ch;
        r.status     = STATUS_OK;
        r.match_mask = '0;
        case (c.func)
            FUNC_INSERT:
            begin
                if (c.first_letter)
                    trie_pos = 0;
                if (c.letter < ALPHA)
                begin
                    trie_built = 1'b0;
                    ch = kid(trie_pos, c.letter);
                    if (ch == 0)
                    begin
                        if (trie_nodes >= MAX_NODES)
                            r.status = STATUS_FULL;
                        else
                        begin
                            ch = trie_nodes++;
                            trie_kid[trie_pos*ALPHA + c.letter] = NODE_W'(ch);
                        end
                    end
                    if (ch != 0)
                    begin
                        trie_pos = ch;
                        if (c.last_letter)
                            trie_mask[trie_pos][c.pattern_id] = 1'b1;
                    end
                end
            end
            FUNC_BUILD:
                build_links();
            FUNC_SCAN:
            begin
                if (!trie_built)
                    r.status = STATUS_EARLY;
                else if (c.letter >= ALPHA)
                begin
                    trie_pos     = 0;
                    r.match_mask = trie_mask[0];
                end
                else
                begin
                    if (c.first_letter)
                        trie_pos = 0;
                    for (int s = 0; s < MAX_NODES; s++)
                    begin
                        if (kid(trie_pos, c.letter) != 0 || trie_pos == 0)
                            break;
                        trie_pos = trie_fail[trie_pos];
                    end
                    if (kid(trie_pos, c.letter) != 0)
                        trie_pos = kid(trie_pos, c.letter);
                    r.match_mask = trie_mask[trie_pos];
                end
            end
            default:
                clear_trie();
        endcase
        r.match_any  = |r.match_mask;
        r.node_index = trie_pos[NODE_W-1:0];
        return r;
    endfunction

    // mostly a few letters so patterns overlap, rarely outside the alphabet
    function automatic logic [4:0] rand_letter();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 5'($urandom_range(0, 3));
        else if (r < 97)
            return 5'($urandom_range(0, ALPHA-1));
        return 5'($urandom_range(ALPHA, 31));
    endfunction

    // drive one transaction, wait for acceptance, log its expectation
    task automatic issue(cmd_t c, bit typed = 1'b0, rsp_t texp = '0);
        int   gap;
        rsp_t e;
        if ($urandom_range(0, 63) == 0)
            no_idle = !no_idle;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        e = trie_step(c);
        pending_rsp.insert(pending_rsp.size(), typed ? texp : e);
        n_sent++;
    endtask

    // response checker
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %p", $time, rsp);
                errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.status !== e.status || rsp.match_mask !== e.match_mask ||
                    rsp.match_any !== e.match_any || rsp.node_index !== e.node_index)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, e, rsp);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= TIMEOUT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int    npat, len, nscan;
        rsp_t  early0;
        rsp_t  ok0;
        rsp_t  ok1;
        errors       = 0;
        n_sent       = 0;
        quiet_cycles = 0;
        no_idle      = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        rst_n        = 1'b0;
        clear_trie();
        early0 = '{STATUS_EARLY, 64'd0, 1'b0, 10'd0};
        ok0    = '{STATUS_OK, 64'd0, 1'b0, 10'd0};
        ok1    = '{STATUS_OK, 64'd0, 1'b0, 10'd1};

        // directed table
        add_row(mk(FUNC_SCAN, 5'd0, 1'b1, 1'b0, 6'd0), 1'b1, early0);
        add_row(mk(FUNC_INSERT, 5'd25, 1'b1, 1'b1, 6'd63), 1'b1, ok1);
        add_row(mk(FUNC_INSERT, 5'd31, 1'b0, 1'b1, 6'd1), 1'b1, ok1);
        add_row(mk(FUNC_INSERT, 5'd0, 1'b1, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_INSERT, 5'd1, 1'b0, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_INSERT, 5'd2, 1'b0, 1'b1, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_INSERT, 5'd1, 1'b1, 1'b0, 6'd42), 1'b0, ok0);
        add_row(mk(FUNC_INSERT, 5'd2, 1'b0, 1'b1, 6'd21), 1'b0, ok0);
        add_row(mk(FUNC_INSERT, 5'd2, 1'b1, 1'b1, 6'd5), 1'b0, ok0);
        add_row(mk(FUNC_SCAN, 5'd2, 1'b1, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_BUILD, 5'd31, 1'b1, 1'b1, 6'd63), 1'b1, ok0);
        add_row(mk(FUNC_SCAN, 5'd0, 1'b1, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_SCAN, 5'd1, 1'b0, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_SCAN, 5'd2, 1'b0, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_SCAN, 5'd25, 1'b0, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_SCAN, 5'd30, 1'b0, 1'b1, 6'd63), 1'b1, ok0);
        add_row(mk(FUNC_SCAN, 5'd2, 1'b0, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_INSERT, 5'd3, 1'b1, 1'b1, 6'd2), 1'b0, ok0);
        add_row(mk(FUNC_SCAN, 5'd3, 1'b1, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_BUILD, 5'd0, 1'b0, 1'b0, 6'd0), 1'b1, ok0);
        add_row(mk(FUNC_SCAN, 5'd3, 1'b0, 1'b0, 6'd0), 1'b0, ok0);
        add_row(mk(FUNC_CLEAR, 5'd0, 1'b0, 1'b0, 6'd0), 1'b1, ok0);
        add_row(mk(FUNC_SCAN, 5'd2, 1'b0, 1'b0, 6'd0), 1'b1, early0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);

        // random pattern sets, mostly built, then scan text
        while (n_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
                issue(mk(FUNC_CLEAR, 5'($urandom), 1'($urandom), 1'($urandom),
                         6'($urandom)));
            npat = $urandom_range(1, 8);
            for (int p = 0; p < npat; p++)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        issue(mk(FUNC_INSERT, rand_letter(), 1'($urandom), 1'($urandom),
                                 6'($urandom)));
                    else
                        issue(mk(FUNC_INSERT, rand_letter(), k == 0, k == len-1,
                                 6'($urandom_range(0, MAX_PAT-1))));
                end
            end
            if ($urandom_range(0, 9) != 0)
                issue(mk(FUNC_BUILD, 5'($urandom), 1'($urandom), 1'($urandom),
                         6'($urandom)));
            nscan = $urandom_range(10, 40);
            for (int s = 0; s < nscan; s++)
            begin
                if ($urandom_range(0, 79) == 0)
                    issue(mk(FUNC_INSERT, rand_letter(), 1'($urandom), 1'($urandom),
                             6'($urandom)));
                else if ($urandom_range(0, 79) == 0)
                    issue(mk(FUNC_BUILD, 5'($urandom), 1'($urandom), 1'($urandom),
                             6'($urandom)));
                issue(mk(FUNC_SCAN, rand_letter(), $urandom_range(0, 15) == 0,
                         1'($urandom), 6'($urandom)));
            end
        end

        // fill the node table, then push past its limit
        issue(mk(FUNC_CLEAR, 5'd0, 1'b0, 1'b0, 6'd0));
        while (trie_nodes < MAX_NODES)
            issue(mk(FUNC_INSERT, 5'($urandom_range(0, ALPHA-1)),
                     $urandom_range(0, 7) == 0, 1'($urandom), 6'($urandom)));
        for (int k = 0; k < 6; k++)
            issue(mk(FUNC_INSERT, 5'($urandom_range(0, ALPHA-1)), 1'b0, 1'b1,
                     6'($urandom)));
        issue(mk(FUNC_BUILD, 5'd0, 1'b0, 1'b0, 6'd0));
        for (int s = 0; s < 20; s++)
            issue(mk(FUNC_SCAN, 5'($urandom_range(0, ALPHA-1)),
                     $urandom_range(0, 15) == 0, 1'b0, 6'd0));
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
